FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Default sizing
    localparam int unsigned SPQ_DEPTH     = 16;
    localparam int unsigned SPQ_KEY_WIDTH = 32;

    // Fixed field widths of the item payloads
    localparam int unsigned IN_KEY_W    = 32;
    localparam int unsigned OUT_KEY_W   = 32;
    localparam int unsigned OUT_COUNT_W = 5;

    // Action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    // Input item
    typedef struct packed {
        logic                action;
        logic [IN_KEY_W-1:0] key;
    } spq_in_t;

    // Result item
    typedef struct packed {
        logic [OUT_KEY_W-1:0]   min_key;
        logic                   is_empty;
        logic [OUT_COUNT_W-1:0] entry_count;
        logic [1:0]             status;
    } spq_out_t;

    // Operation broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_op_t;

endpackage

FILE: design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds a key, compares it to the broadcast
// key and takes a key from its left or right neighbor on insert or remove.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int unsigned KEY_WIDTH = spq_pkg::SPQ_KEY_WIDTH
) (
    input  logic                 aclk,
    input  spq_pkg::spq_op_t     op,
    input  logic [KEY_WIDTH-1:0] in_key,
    input  logic                 occupied,
    input  logic                 left_take,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic [KEY_WIDTH-1:0] right_key,
    output logic                 take,
    output logic [KEY_WIDTH-1:0] key
);
    import spq_pkg::*;

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;

    // Slot lies at or after the insertion point: empty, or holds a larger key
    assign take = !occupied || (in_key < key_reg);

    // Insert: first taking slot gets the new key, later ones shift right.
    // Remove: every slot shifts left.
    always_comb begin
        key_next = key_reg;
        if (op.ins) begin
            if (take) begin
                key_next = left_take ? left_key : in_key;
            end
        end else if (op.rem) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

FILE: design/sorted_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Sorted-list priority queue built as a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Result: registered; it appears in the cycle after the item is accepted.
// Throughput: one item per cycle while m_ready is high; every cell compares
//   the incoming key at once and shifts by one slot: one pass per operation.
// Reset: aresetn (synchronous, active low) empties the queue and drops any
//   pending result; stored keys are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int unsigned DEPTH     = spq_pkg::SPQ_DEPTH,
    parameter int unsigned KEY_WIDTH = spq_pkg::SPQ_KEY_WIDTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  spq_pkg::spq_in_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output spq_pkg::spq_out_t m_data
);
    import spq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [KEY_WIDTH-1:0] in_key;
    logic [KEY_WIDTH+IN_KEY_W-1:0] in_key_ext;
    spq_op_t              op;

    logic [KEY_WIDTH-1:0] cell_key  [DEPTH];
    logic                 cell_take [DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    spq_status_t          status_reg;
    spq_status_t          status_next;
    logic                 m_valid_reg;

    logic [KEY_WIDTH+OUT_KEY_W-1:0]   min_ext;
    logic [CNT_W+OUT_COUNT_W-1:0]     count_ext;

    // Handshake: output register frees up when the result is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Fit the incoming key to the stored width
    assign in_key_ext = {{KEY_WIDTH{1'b0}}, s_data.key};
    assign in_key     = in_key_ext[KEY_WIDTH-1:0];

    // Operation decode
    always_comb begin
        op.ins      = 1'b0;
        op.rem      = 1'b0;
        count_next  = count_reg;
        status_next = ST_OK;
        if (s_data.action == ACT_INSERT) begin
            if (full) begin
                status_next = ST_FULL;
            end else begin
                op.ins     = accept;
                count_next = count_reg + 1'b1;
            end
        end else begin
            if (empty) begin
                status_next = ST_EMPTY;
            end else begin
                op.rem     = accept;
                count_next = count_reg - 1'b1;
            end
        end
    end

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 occ;
        logic                 l_take;
        logic [KEY_WIDTH-1:0] l_key;
        logic [KEY_WIDTH-1:0] r_key;

        assign occ = (CNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            assign l_take = 1'b0;
            assign l_key  = in_key;
        end else begin : g_mid
            assign l_take = cell_take[i-1];
            assign l_key  = cell_key[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign r_key = cell_key[i];
        end else begin : g_inner
            assign r_key = cell_key[i+1];
        end

        spq_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .op        (op),
            .in_key    (in_key),
            .occupied  (occ),
            .left_take (l_take),
            .left_key  (l_key),
            .right_key (r_key),
            .take      (cell_take[i]),
            .key       (cell_key[i])
        );
    end

    // Count, status and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                status_reg  <= status_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result fields come straight from the state registers
    assign min_ext   = {{OUT_KEY_W{1'b0}}, cell_key[0]};
    assign count_ext = {{OUT_COUNT_W{1'b0}}, count_reg};

    assign m_valid            = m_valid_reg;
    assign m_data.min_key     = empty ? '0 : min_ext[OUT_KEY_W-1:0];
    assign m_data.is_empty    = empty;
    assign m_data.entry_count = count_ext[OUT_COUNT_W-1:0];
    assign m_data.status      = status_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        op.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && status_reg == ST_FULL |-> full)
        else $error("full status with room left");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && status_reg == ST_EMPTY |-> empty)
        else $error("empty status with keys stored");

endmodule
